>>> hdl/trigger_inflight_tracker_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the trigger in-flight tracker
// Shared implication checks, clocked on clk and quiet during reset.
// ---------------------------------------------------------------------------
`ifndef TRIGGER_INFLIGHT_TRACKER_ASSERT_SVH
`define TRIGGER_INFLIGHT_TRACKER_ASSERT_SVH

// same-cycle implication
`define TIT_ASSERT_NOW(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("tracker check failed");

// next-cycle implication
`define TIT_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("tracker check failed");

`endif

>>> hdl/tit_pkg.sv
// ---------------------------------------------------------------------------
// Trigger in-flight tracker package
// Beat types, table entry layout, codes and controller handshake structs.
// ---------------------------------------------------------------------------
package tit_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	localparam logic [1:0] KIND_DECISION = 2'd0;
	localparam logic [1:0] KIND_BUILT    = 2'd1;
	localparam logic [1:0] KIND_TOKEN    = 2'd2;
	localparam logic [1:0] KIND_NONE     = 2'd3;

	localparam logic [1:0] REG_CURRENT_RUN = 2'd0;
	localparam logic [1:0] REG_BUSY_THR    = 2'd1;
	localparam logic [1:0] REG_FREE_THR    = 2'd2;

	localparam logic [3:0] STS_ACCEPTED   = 4'd0;
	localparam logic [3:0] STS_WRONG_RUN  = 4'd1;
	localparam logic [3:0] STS_DUPLICATE  = 4'd2;
	localparam logic [3:0] STS_FULL       = 4'd3;
	localparam logic [3:0] STS_UNEXP_DONE = 4'd4;
	localparam logic [3:0] STS_PARTIAL    = 4'd5;
	localparam logic [3:0] STS_BUILT      = 4'd6;
	localparam logic [3:0] STS_UNEXP_TOK  = 4'd7;
	localparam logic [3:0] STS_PART_TOK   = 4'd8;
	localparam logic [3:0] STS_RETIRED    = 4'd9;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] run_id;
		logic [63:0] trigger_num;
		logic [15:0] max_seq;
		logic [31:0] record_bytes;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic        forward_decision;
		logic        early_token;
		logic        busy_res;
		logic [6:0]  workload;
		logic [31:0] records_done;
		logic [63:0] bytes_written;
	} out_item_t;

	typedef struct packed {
		logic [31:0] run;
		logic [63:0] trig;
		logic        writing;
		logic        multi;
		logic [15:0] last_seq;
		logic [16:0] built;
		logic [16:0] written;
	} slot_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_EXEC
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic scan_en;
		logic exec;
	} ctl_cmd_t;

	typedef struct packed {
		logic drop;
		logic direct;
		logic scan_done;
		logic out_free;
	} dp_sts_t;

endpackage

>>> hdl/tit_ctrl.sv
// ---------------------------------------------------------------------------
// Tracker controller
// Sequences accept, table scan and table update for one event at a time.
// ---------------------------------------------------------------------------
module tit_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tit_pkg::dp_sts_t  sts,
	output tit_pkg::ctl_cmd_t cmd
);

	tit_pkg::ctl_state_t state_q;
	tit_pkg::ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tit_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tit_pkg::S_IDLE: begin
				if (in_valid) state_d = tit_pkg::S_SCAN;
			end
			tit_pkg::S_SCAN: begin
				if (sts.drop) state_d = tit_pkg::S_IDLE;
				else if (sts.direct || sts.scan_done) state_d = tit_pkg::S_EXEC;
			end
			tit_pkg::S_EXEC: begin
				if (sts.out_free) state_d = tit_pkg::S_IDLE;
			end
			default: state_d = tit_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		case (state_q)
			tit_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			tit_pkg::S_SCAN: begin
				cmd.scan_en = 1'b1;
			end
			tit_pkg::S_EXEC: begin
				cmd.exec = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

`include "trigger_inflight_tracker_assert.svh"

	`TIT_ASSERT_NEXT(a_accept_scans, in_valid && in_ready, state_q == tit_pkg::S_SCAN)
	`TIT_ASSERT_NEXT(a_drop_idles, state_q == tit_pkg::S_SCAN && sts.drop, state_q == tit_pkg::S_IDLE)
	`TIT_ASSERT_NEXT(a_exec_idles, state_q == tit_pkg::S_EXEC && sts.out_free, state_q == tit_pkg::S_IDLE)

endmodule

>>> hdl/tit_datapath.sv
// ---------------------------------------------------------------------------
// Tracker datapath
// Slot table memory, sequential slot scan, event update and result register.
// ---------------------------------------------------------------------------
module tit_datapath #(
	parameter int TABLE_DEPTH = tit_pkg::TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tit_pkg::in_item_t  in_item,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  tit_pkg::ctl_cmd_t  cmd,
	output tit_pkg::dp_sts_t   sts,
	output logic               out_valid,
	input  logic               out_ready,
	output tit_pkg::out_item_t out_item
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = AW + 1;
	localparam int LW = $clog2(TABLE_DEPTH + 1);
	localparam int KW = (LW > 7) ? LW : 7;

	tit_pkg::slot_t    mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] used_q;

	tit_pkg::in_item_t in_q;
	logic [31:0]       run_cfg_q;
	logic [6:0]        busy_thr_q;
	logic [6:0]        free_thr_q;

	logic [CW-1:0]     cnt_q;
	logic              vld_s1;
	logic [AW-1:0]     idx_s1;
	tit_pkg::slot_t    rd_s1;
	logic              hit_q;
	logic [AW-1:0]     hit_idx_q;
	tit_pkg::slot_t    hit_ent_q;
	logic              free_q;
	logic [AW-1:0]     free_idx_q;

	logic [LW-1:0]     load_q;
	logic              busy_q;
	logic [31:0]       retired_q;
	logic [63:0]       bytes_q;
	logic              out_valid_q;
	tit_pkg::out_item_t out_q;

	logic              issue;
	logic              wrong_run;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	tit_pkg::slot_t    wr_ent;
	logic              used_set;
	logic              used_clr;
	logic              retire;
	logic              upd_busy;
	logic [LW-1:0]     load_d;
	logic [KW-1:0]     load_x;
	logic              busy_d;
	logic [3:0]        status;
	logic              fwd;
	logic              early;
	logic [16:0]       cnt_nx;
	logic [16:0]       last_p1;
	logic              done;

	assign wrong_run = (in_q.kind == tit_pkg::KIND_DECISION) && (in_q.run_id != run_cfg_q);
	assign issue     = cmd.scan_en && !hit_q && (cnt_q != CW'(TABLE_DEPTH));

	assign sts.drop      = (in_q.kind == tit_pkg::KIND_NONE);
	assign sts.direct    = wrong_run;
	assign sts.scan_done = hit_q || ((cnt_q == CW'(TABLE_DEPTH)) && !vld_s1);
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_cfg_q  <= '0;
			busy_thr_q <= 7'd48;
			free_thr_q <= 7'd32;
		end else if (cfg_valid) begin
			case (cfg_index)
				tit_pkg::REG_CURRENT_RUN: run_cfg_q  <= cfg_data;
				tit_pkg::REG_BUSY_THR:    busy_thr_q <= cfg_data[6:0];
				tit_pkg::REG_FREE_THR:    free_thr_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) in_q <= in_item;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) mem[wr_addr] <= wr_ent;
		rd_s1 <= mem[cnt_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (issue) cnt_q <= cnt_q + 1'b1;
			if (vld_s1 && !hit_q) begin
				if (used_q[idx_s1] && rd_s1.run == in_q.run_id && rd_s1.trig == in_q.trigger_num)
					hit_q <= 1'b1;
				if (!used_q[idx_s1] && !free_q) free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[AW-1:0];
		if (vld_s1 && !hit_q) begin
			hit_idx_q <= idx_s1;
			hit_ent_q <= rd_s1;
			if (!used_q[idx_s1] && !free_q) free_idx_q <= idx_s1;
		end
	end

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = hit_idx_q;
		wr_ent   = hit_ent_q;
		used_set = 1'b0;
		used_clr = 1'b0;
		retire   = 1'b0;
		upd_busy = 1'b0;
		load_d   = load_q;
		status   = tit_pkg::STS_ACCEPTED;
		fwd      = 1'b0;
		early    = 1'b0;
		cnt_nx   = '0;
		done     = 1'b1;
		last_p1  = {1'b0, hit_ent_q.last_seq} + 17'd1;
		case (in_q.kind)
			tit_pkg::KIND_DECISION: begin
				if (wrong_run) begin
					status = tit_pkg::STS_WRONG_RUN;
				end else if (hit_q) begin
					status = tit_pkg::STS_DUPLICATE;
				end else if (!free_q) begin
					status = tit_pkg::STS_FULL;
				end else begin
					wr_en    = 1'b1;
					wr_addr  = free_idx_q;
					wr_ent   = '0;
					wr_ent.run  = in_q.run_id;
					wr_ent.trig = in_q.trigger_num;
					used_set = 1'b1;
					load_d   = load_q + 1'b1;
					upd_busy = 1'b1;
					fwd      = 1'b1;
				end
			end
			tit_pkg::KIND_BUILT: begin
				if (!hit_q || hit_ent_q.writing) begin
					status = tit_pkg::STS_UNEXP_DONE;
				end else begin
					if (in_q.max_seq != 16'd0) begin
						if (!hit_ent_q.multi) begin
							wr_ent.multi    = 1'b1;
							wr_ent.last_seq = in_q.max_seq;
							wr_ent.built    = 17'd1;
							wr_ent.written  = 17'd0;
						end else begin
							wr_ent.built = hit_ent_q.built + 17'd1;
						end
						done = (wr_ent.built == {1'b0, wr_ent.last_seq} + 17'd1);
					end
					wr_en = 1'b1;
					if (done) begin
						wr_ent.writing = 1'b1;
						status = tit_pkg::STS_BUILT;
					end else begin
						status = tit_pkg::STS_PARTIAL;
					end
				end
			end
			tit_pkg::KIND_TOKEN: begin
				if (!hit_q) begin
					status = tit_pkg::STS_UNEXP_TOK;
				end else begin
					early = !hit_ent_q.writing;
					if (hit_ent_q.multi) begin
						cnt_nx = hit_ent_q.written + 17'd1;
						wr_ent.written = cnt_nx;
						done = (cnt_nx == last_p1);
					end
					if (done) begin
						used_clr = 1'b1;
						retire   = 1'b1;
						upd_busy = 1'b1;
						if (load_q != '0) load_d = load_q - 1'b1;
						status = tit_pkg::STS_RETIRED;
					end else begin
						wr_en  = 1'b1;
						status = tit_pkg::STS_PART_TOK;
					end
				end
			end
			default: begin
				status = tit_pkg::STS_ACCEPTED;
			end
		endcase
		load_x = KW'(load_d);
		busy_d = busy_q;
		if (upd_busy) begin
			if (busy_d && load_x < KW'(free_thr_q)) busy_d = 1'b0;
			if (!busy_d && load_x > KW'(busy_thr_q)) busy_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			load_q      <= '0;
			busy_q      <= 1'b0;
			retired_q   <= '0;
			bytes_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) out_valid_q <= 1'b0;
			if (cmd.exec) begin
				if (used_set) used_q[free_idx_q] <= 1'b1;
				if (used_clr) used_q[hit_idx_q]  <= 1'b0;
				load_q <= load_d;
				busy_q <= busy_d;
				if (retire) begin
					retired_q <= retired_q + 32'd1;
					bytes_q   <= bytes_q + {32'd0, in_q.record_bytes};
				end
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_q.status           <= status;
			out_q.forward_decision <= fwd;
			out_q.early_token      <= early;
			out_q.busy_res         <= busy_d;
			out_q.workload         <= load_x[6:0];
			out_q.records_done     <= retire ? retired_q + 32'd1 : retired_q;
			out_q.bytes_written    <= retire ? bytes_q + {32'd0, in_q.record_bytes} : bytes_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`include "trigger_inflight_tracker_assert.svh"

	`TIT_ASSERT_NOW(a_exec_has_room, cmd.exec, !out_valid_q || out_ready)
	`TIT_ASSERT_NEXT(a_exec_shows, cmd.exec, out_valid_q)
	`TIT_ASSERT_NOW(a_load_bound, 1'b1, load_q <= LW'(TABLE_DEPTH))

endmodule

>>> hdl/trigger_inflight_tracker.sv
// ---------------------------------------------------------------------------
// Trigger in-flight tracker
// Top level: controller plus slot table datapath.
// ---------------------------------------------------------------------------
// Each event takes one beat and, except for unused kinds and wrong-run
// decisions, walks the slot table memory one slot per cycle until a match or
// the end; the result lands in an output register that may wait while the
// next event is taken. Config writes are taken every cycle.
module trigger_inflight_tracker #(
	parameter int TABLE_DEPTH = tit_pkg::TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tit_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output tit_pkg::out_item_t out_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	tit_pkg::ctl_cmd_t cmd;
	tit_pkg::dp_sts_t  sts;

	assign cfg_ready = 1'b1;

	tit_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tit_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

>>> dv/tb_trigger_inflight_tracker.sv
// ---------------------------------------------------------------------------
// Trigger in-flight tracker testbench
// Drives decision, completion and token beats, predicts every result with a
// local table model and compares each output beat field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_trigger_inflight_tracker;

	localparam int DEPTH = tit_pkg::TABLE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	tit_pkg::in_item_t in_item;
	logic out_valid;
	logic out_ready;
	tit_pkg::out_item_t out_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	trigger_inflight_tracker i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// tracker state mirror
	logic [31:0] run_reg;
	logic [6:0] busy_thr;
	logic [6:0] free_thr;
	logic used [DEPTH];
	tit_pkg::slot_t slots [DEPTH];
	logic busy_q;
	logic [6:0] load_q;
	logic [31:0] retired_q;
	logic [63:0] bytes_q;

	tit_pkg::in_item_t event_q[$];
	tit_pkg::out_item_t result_q[$];
	int errors = 0;
	int results_seen = 0;
	int cycles = 0;
	int send_idle = 0;
	int recv_idle = 0;
	logic send_hold = 0;
	logic stall_req = 0;
	logic stall_done = 0;
	int stall_len = 0;
	logic [63:0] trig_pool [16];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int lookup(logic [31:0] run, logic [63:0] trig);
		for (int i = 0; i < DEPTH; i++)
			if (used[i] && slots[i].run == run && slots[i].trig == trig)
				return i;
		return -1;
	endfunction

	function automatic void refresh_busy();
		if (busy_q && load_q < free_thr)
			busy_q = 1'b0;
		if (!busy_q && load_q > busy_thr)
			busy_q = 1'b1;
	endfunction

	function automatic void predict_event(tit_pkg::in_item_t ev);
		tit_pkg::out_item_t r;
		int s;
		logic done;
		r = '0;
		if (ev.kind == tit_pkg::KIND_NONE)
			return;
		if (ev.kind == tit_pkg::KIND_DECISION) begin
			if (ev.run_id != run_reg) begin
				r.status = tit_pkg::STS_WRONG_RUN;
			end else if (lookup(ev.run_id, ev.trigger_num) >= 0) begin
				r.status = tit_pkg::STS_DUPLICATE;
			end else begin
				s = -1;
				for (int i = DEPTH - 1; i >= 0; i--)
					if (!used[i])
						s = i;
				if (s < 0) begin
					r.status = tit_pkg::STS_FULL;
				end else begin
					used[s] = 1'b1;
					slots[s] = '0;
					slots[s].run = ev.run_id;
					slots[s].trig = ev.trigger_num;
					load_q = load_q + 7'd1;
					refresh_busy();
					r.status = tit_pkg::STS_ACCEPTED;
					r.forward_decision = 1'b1;
				end
			end
		end else if (ev.kind == tit_pkg::KIND_BUILT) begin
			s = lookup(ev.run_id, ev.trigger_num);
			if (s < 0 || slots[s].writing) begin
				r.status = tit_pkg::STS_UNEXP_DONE;
			end else begin
				done = 1'b1;
				if (ev.max_seq != 16'd0) begin
					if (!slots[s].multi) begin
						slots[s].multi = 1'b1;
						slots[s].last_seq = ev.max_seq;
						slots[s].built = 17'd1;
						slots[s].written = '0;
					end else begin
						slots[s].built = slots[s].built + 17'd1;
					end
					done = (slots[s].built == {1'b0, slots[s].last_seq} + 17'd1);
				end
				if (done) begin
					slots[s].writing = 1'b1;
					r.status = tit_pkg::STS_BUILT;
				end else begin
					r.status = tit_pkg::STS_PARTIAL;
				end
			end
		end else begin
			s = lookup(ev.run_id, ev.trigger_num);
			if (s < 0) begin
				r.status = tit_pkg::STS_UNEXP_TOK;
			end else begin
				done = 1'b1;
				r.early_token = !slots[s].writing;
				if (slots[s].multi) begin
					slots[s].written = slots[s].written + 17'd1;
					done = (slots[s].written == {1'b0, slots[s].last_seq} + 17'd1);
				end
				if (done) begin
					used[s] = 1'b0;
					if (load_q > 7'd0)
						load_q = load_q - 7'd1;
					retired_q = retired_q + 32'd1;
					bytes_q = bytes_q + {32'd0, ev.record_bytes};
					refresh_busy();
					r.status = tit_pkg::STS_RETIRED;
				end else begin
					r.status = tit_pkg::STS_PART_TOK;
				end
			end
		end
		r.busy_res = busy_q;
		r.workload = load_q;
		r.records_done = retired_q;
		r.bytes_written = bytes_q;
		result_q.push_back(r);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
		end else begin
			if (in_valid && in_ready)
				predict_event(in_item);
			if ((!in_valid || in_ready) && !send_hold && event_q.size() > 0
					&& $urandom_range(99) >= send_idle) begin
				in_valid <= 1'b1;
				in_item <= event_q.pop_front();
			end else if (in_valid && in_ready) begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (result_q.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual %p", $time, out_item);
					errors <= errors + 1;
				end else begin
					tit_pkg::out_item_t e;
					e = result_q.pop_front();
					if (e.status !== out_item.status || e.forward_decision !== out_item.forward_decision
							|| e.early_token !== out_item.early_token
							|| e.busy_res !== out_item.busy_res
							|| e.workload !== out_item.workload
							|| e.records_done !== out_item.records_done
							|| e.bytes_written !== out_item.bytes_written) begin
						$display("%0t: mismatch, expected %p, actual %p", $time, e, out_item);
						errors <= errors + 1;
					end
				end
			end
			if (stall_req && !stall_done) begin
				stall_done <= 1'b1;
				stall_len <= 3000;
				out_ready <= 1'b0;
			end else if (stall_len > 0) begin
				stall_len <= stall_len - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	task automatic wait_drained();
		while (event_q.size() > 0 || in_valid || result_q.size() > 0 || !in_ready)
			@(negedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			tit_pkg::REG_CURRENT_RUN: run_reg = val;
			tit_pkg::REG_BUSY_THR: busy_thr = val[6:0];
			tit_pkg::REG_FREE_THR: free_thr = val[6:0];
			default: ;
		endcase
	endtask

	function automatic tit_pkg::in_item_t make_event(logic [1:0] k, logic [31:0] run,
			logic [63:0] trig, logic [15:0] mseq, logic [31:0] nbytes);
		tit_pkg::in_item_t ev;
		ev.kind = k;
		ev.run_id = run;
		ev.trigger_num = trig;
		ev.max_seq = mseq;
		ev.record_bytes = nbytes;
		return ev;
	endfunction

	// one trigger life: decision, then completions, then tokens, in that order
	task automatic push_life(logic [63:0] trig);
		logic [15:0] m;
		int n;
		m = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(3));
		n = m + 1;
		event_q.push_back(make_event(tit_pkg::KIND_DECISION, run_reg, trig, '0, '0));
		for (int i = 0; i < n; i++)
			event_q.push_back(make_event(tit_pkg::KIND_BUILT, run_reg, trig,
				(i == 0 || $urandom_range(9) > 0) ? m : 16'd0, $urandom));
		if ($urandom_range(4) == 0)
			event_q.push_back(make_event(tit_pkg::KIND_BUILT, run_reg, trig, m, '0));
		for (int i = 0; i < n; i++)
			event_q.push_back(make_event(tit_pkg::KIND_TOKEN, run_reg, trig, 16'($urandom),
				($urandom_range(5) == 0) ? 32'hFFFF_FFFF : $urandom));
	endtask

	task automatic push_random(int count);
		logic [63:0] t;
		for (int i = 0; i < count; i++) begin
			t = trig_pool[$urandom_range(15)];
			case ($urandom_range(9))
				0: event_q.push_back(make_event(2'($urandom), $urandom, {$urandom, $urandom},
					16'($urandom), $urandom));
				1: event_q.push_back(make_event(2'($urandom_range(2)), run_reg, t,
					16'($urandom_range(2)), $urandom));
				default: begin
					push_life({$urandom, $urandom});
					i += 3;
				end
			endcase
		end
	endtask

	initial begin
		run_reg = '0;
		busy_thr = 7'd48;
		free_thr = 7'd32;
		busy_q = 0;
		load_q = 0;
		retired_q = 0;
		bytes_q = 0;
		for (int i = 0; i < DEPTH; i++) begin
			used[i] = 1'b0;
			slots[i] = '0;
		end
		for (int i = 0; i < 16; i++)
			trig_pool[i] = {$urandom, $urandom};
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every kind and every status but full, unused kind
		write_reg(tit_pkg::REG_CURRENT_RUN, 32'hFFFF_FFFF);
		write_reg(tit_pkg::REG_BUSY_THR, 32'd1);
		write_reg(tit_pkg::REG_FREE_THR, 32'd64);
		event_q.push_back(make_event(tit_pkg::KIND_DECISION, 32'hFFFF_FFFF, '1, '1, '1));
		event_q.push_back(make_event(tit_pkg::KIND_DECISION, 32'h0, 64'd0, '0, '0));
		event_q.push_back(make_event(tit_pkg::KIND_DECISION, 32'hFFFF_FFFF, '1, '0, '0));
		event_q.push_back(make_event(tit_pkg::KIND_DECISION, 32'hFFFF_FFFF, 64'd0, '0, '0));
		event_q.push_back(make_event(tit_pkg::KIND_DECISION, 32'hFFFF_FFFF, 64'd1, '0, '0));
		event_q.push_back(make_event(tit_pkg::KIND_TOKEN, 32'hFFFF_FFFF, 64'd0, '0, '1));
		event_q.push_back(make_event(tit_pkg::KIND_BUILT, 32'hFFFF_FFFF, '1, 16'd2, '0));
		event_q.push_back(make_event(tit_pkg::KIND_BUILT, 32'hFFFF_FFFF, '1, 16'd0, '0));
		event_q.push_back(make_event(tit_pkg::KIND_BUILT, 32'hFFFF_FFFF, '1, 16'd1, '0));
		event_q.push_back(make_event(tit_pkg::KIND_TOKEN, 32'hFFFF_FFFF, '1, '0, '1));
		event_q.push_back(make_event(tit_pkg::KIND_TOKEN, 32'hFFFF_FFFF, '1, '0, '1));
		event_q.push_back(make_event(tit_pkg::KIND_TOKEN, 32'hFFFF_FFFF, '1, '0, '1));
		event_q.push_back(make_event(tit_pkg::KIND_BUILT, 32'h1234, 64'd5, '1, '0));
		event_q.push_back(make_event(tit_pkg::KIND_TOKEN, 32'h1234, 64'd5, '0, '0));
		event_q.push_back(make_event(tit_pkg::KIND_NONE, '1, '1, '1, '1));
		event_q.push_back(make_event(tit_pkg::KIND_BUILT, 32'hFFFF_FFFF, 64'd1, 16'hFFFF, '0));
		event_q.push_back(make_event(tit_pkg::KIND_TOKEN, 32'hFFFF_FFFF, 64'd1, '0, 32'd7));
		wait_drained();

		// fill the table past full while the receiver holds off
		write_reg(tit_pkg::REG_CURRENT_RUN, 32'd0);
		write_reg(tit_pkg::REG_BUSY_THR, 32'd64);
		write_reg(tit_pkg::REG_FREE_THR, 32'd0);
		stall_req = 1'b1;
		for (int i = 0; i < 70; i++)
			event_q.push_back(make_event(tit_pkg::KIND_DECISION, 32'd0, 64'(i), '0, '0));
		wait_drained();
		for (int i = 0; i < 70; i++)
			event_q.push_back(make_event(tit_pkg::KIND_TOKEN, 32'd0, 64'(i), '0, $urandom));
		wait_drained();

		// random phases with varied thresholds and idling
		write_reg(tit_pkg::REG_CURRENT_RUN, $urandom);
		write_reg(tit_pkg::REG_BUSY_THR, 32'd3);
		write_reg(tit_pkg::REG_FREE_THR, 32'd2);
		send_idle = 7;
		recv_idle = 60;
		push_random(160);
		wait_drained();
		write_reg(tit_pkg::REG_CURRENT_RUN, $urandom);
		write_reg(tit_pkg::REG_BUSY_THR, 32'd0);
		write_reg(tit_pkg::REG_FREE_THR, 32'd1);
		send_idle = 60;
		recv_idle = 7;
		push_random(160);
		// pause the sender until every expected beat has come
		repeat (2000) @(posedge clk);
		send_hold = 1;
		while (in_valid || result_q.size() > 0)
			@(negedge clk);
		send_hold = 0;
		wait_drained();
		write_reg(tit_pkg::REG_BUSY_THR, 32'd2);
		write_reg(tit_pkg::REG_FREE_THR, 32'd5);
		send_idle = 0;
		recv_idle = 0;
		push_random(160);
		wait_drained();

		$display("Covered all event kinds, table full, run/threshold extremes, %0d results.",
			results_seen);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
